// ===== rtl/label_grid_boundary_detect_unit_macros.svh =====
// Assertion macros shared by the boundary detect RTL
`ifndef LABEL_GRID_BOUNDARY_DETECT_UNIT_MACROS_SVH
`define LABEL_GRID_BOUNDARY_DETECT_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, clocked on clk, off while rst_n is low
`define LGBD_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, clocked on clk, off while rst_n is low
`define LGBD_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LGBD_ASSERT_IMP(name, ante, cons, msg)
`define LGBD_ASSERT_NXT(name, ante, cons, msg)
`endif
`endif

// ===== rtl/lgbd_pkg.sv =====
// Shared types and constants of the label grid boundary detect unit
package lgbd_pkg;

  // fixed field widths of the stream items
  localparam int CELL_XW     = 10;
  localparam int CELL_YW     = 10;
  localparam int LABEL_W     = 16;
  localparam int CFG_W       = 11;
  localparam int CFG_IDX_W   = 1;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_PAD_W   = OUT_TDATA_W - (CELL_XW + CELL_YW + LABEL_W + 1);

  // grid size after reset
  localparam logic [CFG_W-1:0] GRID_RESET = 11'd1024;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_WIDTH  = 1'b0,
    CFG_GRID_HEIGHT = 1'b1
  } cfg_reg_t;

  // input item kinds
  typedef enum logic {
    MODE_CELL  = 1'b0,
    MODE_FLUSH = 1'b1
  } mode_t;

  // control of one item handed from the counter stage to the judge stage
  typedef struct packed {
    logic valid;     // item yields a result
    logic drain;     // result comes from a flush step
    logic edge_hit;  // cell lies on a grid edge
    logic last;      // final cell of the frame
    logic par;       // line buffer that holds the judged row
  } s0_ctl_t;

endpackage

// ===== rtl/lgbd_ram.sv =====
// Generic single-write, single-read RAM with registered read data
module lgbd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // read returns the old entry when the same address is written
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/lgbd_ctrl.sv =====
// Raster counters, configuration, line buffer addressing and row window
`include "label_grid_boundary_detect_unit_macros.svh"
module lgbd_ctrl #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int XW         = 11,
  parameter int YW         = 11,
  parameter int AW         = 10,
  parameter int LW         = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration writes
  input  logic                          cfg_valid,
  input  logic [lgbd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lgbd_pkg::CFG_W-1:0]    cfg_data,
  // input item
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic                          in_mode,
  input  logic [LW-1:0]                 in_label,
  // line buffers
  input  logic [LW-1:0]                 rdata0,
  input  logic [LW-1:0]                 rdata1,
  output logic                          we0,
  output logic                          we1,
  output logic [AW-1:0]                 waddr,
  output logic [LW-1:0]                 wdata,
  output logic                          re,
  output logic [AW-1:0]                 raddr0,
  output logic [AW-1:0]                 raddr1,
  // item toward the judge stage
  output lgbd_pkg::s0_ctl_t             s0_ctl,
  output logic [XW-1:0]                 s0_x,
  output logic [YW-1:0]                 s0_y,
  output logic [LW-1:0]                 s0_lab,
  output logic [LW-1:0]                 s0_left,
  output logic [LW-1:0]                 s0_center
);
  import lgbd_pkg::*;

  function automatic logic [XW-1:0] clamp_w(logic [CFG_W-1:0] v);
    logic [XW-1:0] res;
    if (v == '0) begin
      res = XW'(1);
    end else if (32'(v) > MAX_WIDTH) begin
      res = XW'(MAX_WIDTH);
    end else begin
      res = XW'(v);
    end
    return res;
  endfunction

  function automatic logic [YW-1:0] clamp_h(logic [CFG_W-1:0] v);
    logic [YW-1:0] res;
    if (v == '0) begin
      res = YW'(1);
    end else if (32'(v) > MAX_HEIGHT) begin
      res = YW'(MAX_HEIGHT);
    end else begin
      res = YW'(v);
    end
    return res;
  endfunction

  logic [XW-1:0] width_r;
  logic [YW-1:0] height_r;
  logic [XW-1:0] col_r, col_nxt;
  logic [YW-1:0] row_r, row_nxt;
  logic [XW-1:0] drain_r, drain_nxt;
  logic          full_r, full_nxt;
  logic [LW-1:0] first_r;
  logic [LW-1:0] win_c_r;

  logic          accept;
  logic          do_judge;
  logic          do_drain;
  logic [XW-1:0] x_inc;
  logic [XW-1:0] d_inc;
  logic [YW-1:0] row_inc;
  logic          row_end;
  logic          drain_last;
  logic          cur;
  logic [LW-1:0] rd_prev;
  logic [LW-1:0] center_new;

  // item decode
  assign accept     = in_valid && in_ready;
  assign do_judge   = accept && (in_mode == MODE_CELL) && !full_r;
  assign do_drain   = accept && (in_mode == MODE_FLUSH) && full_r;
  assign x_inc      = col_r + 1'b1;
  assign d_inc      = drain_r + 1'b1;
  assign row_inc    = row_r + 1'b1;
  assign row_end    = x_inc >= width_r;
  assign drain_last = d_inc >= width_r;
  assign cur        = row_r[0];

  // line buffer ports: the row being received is written at its column and
  // read there first (row above the judged cell); the judged row is read one
  // column ahead, or at the drain column during flush
  assign we0    = do_judge && !cur;
  assign we1    = do_judge && cur;
  assign waddr  = col_r[AW-1:0];
  assign wdata  = in_label;
  assign re     = do_judge || do_drain;
  assign raddr0 = do_drain ? drain_r[AW-1:0] : (cur ? x_inc[AW-1:0] : col_r[AW-1:0]);
  assign raddr1 = do_drain ? drain_r[AW-1:0] : (cur ? col_r[AW-1:0] : x_inc[AW-1:0]);

  // center of the window: first cell of the row comes from its own register,
  // later cells from the read issued one item earlier
  assign rd_prev    = cur ? rdata0 : rdata1;
  assign center_new = (col_r == '0) ? first_r : rd_prev;

  // item toward the judge stage
  assign s0_ctl.valid    = do_drain || (do_judge && (row_r != '0));
  assign s0_ctl.drain    = do_drain;
  assign s0_ctl.edge_hit = (row_r == YW'(1)) || (row_r >= height_r) ||
                           (col_r == '0) || row_end;
  assign s0_ctl.last     = do_drain && drain_last;
  assign s0_ctl.par      = !cur;
  assign s0_x            = do_drain ? drain_r : col_r;
  assign s0_y            = row_r - 1'b1;
  assign s0_lab          = in_label;
  assign s0_left         = win_c_r;
  assign s0_center       = center_new;

  // next raster position
  always_comb begin
    col_nxt   = col_r;
    row_nxt   = row_r;
    drain_nxt = drain_r;
    full_nxt  = full_r;
    if (do_judge) begin
      if (row_end) begin
        col_nxt = '0;
        row_nxt = row_inc;
        if (row_inc >= height_r) begin
          full_nxt  = 1'b1;
          drain_nxt = '0;
        end
      end else begin
        col_nxt = x_inc;
      end
    end else if (do_drain) begin
      if (drain_last) begin
        col_nxt   = '0;
        row_nxt   = '0;
        drain_nxt = '0;
        full_nxt  = 1'b0;
      end else begin
        drain_nxt = d_inc;
      end
    end
  end

  // control registers and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= clamp_w(GRID_RESET);
      height_r <= clamp_h(GRID_RESET);
      col_r    <= '0;
      row_r    <= '0;
      drain_r  <= '0;
      full_r   <= 1'b0;
    end else begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      drain_r <= drain_nxt;
      full_r  <= full_nxt;
      if (cfg_valid) begin
        unique case (cfg_reg_t'(cfg_index))
          CFG_GRID_WIDTH:  width_r  <= clamp_w(cfg_data);
          CFG_GRID_HEIGHT: height_r <= clamp_h(cfg_data);
          default: ;
        endcase
      end
    end
  end

  // row window: previous center and first label of the row
  always_ff @(posedge clk) begin
    if (do_judge) begin
      win_c_r <= center_new;
      if (col_r == '0) begin
        first_r <= in_label;
      end
    end
  end

  `LGBD_ASSERT_IMP(a_full_col_zero, full_r, col_r == '0, "column moved while frame full")
  `LGBD_ASSERT_IMP(a_drain_idle, !full_r, drain_r == '0, "drain count set outside drain")
  `LGBD_ASSERT_NXT(a_frame_restart, do_drain && drain_last, !full_r && (row_r == '0),
                   "frame did not restart after last drained cell")

endmodule

// ===== rtl/lgbd_judge.sv =====
// Judge stage and result register of the boundary detect unit
`include "label_grid_boundary_detect_unit_macros.svh"
module lgbd_judge #(
  parameter int XW = 11,
  parameter int YW = 11,
  parameter int LW = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  lgbd_pkg::s0_ctl_t               s0_ctl,
  input  logic [XW-1:0]                   s0_x,
  input  logic [YW-1:0]                   s0_y,
  input  logic [LW-1:0]                   s0_lab,
  input  logic [LW-1:0]                   s0_left,
  input  logic [LW-1:0]                   s0_center,
  input  logic [LW-1:0]                   rdata0,
  input  logic [LW-1:0]                   rdata1,
  output logic                            s1_ready,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [lgbd_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tlast
);
  import lgbd_pkg::*;

  logic          s1_valid_r;
  s0_ctl_t       s1_ctl_r;
  logic [XW-1:0] s1_x_r;
  logic [YW-1:0] s1_y_r;
  logic [LW-1:0] s1_lab_r;
  logic [LW-1:0] s1_left_r;
  logic [LW-1:0] s1_center_r;

  logic                 out_valid_r;
  logic [CELL_XW-1:0]   out_x_r;
  logic [CELL_YW-1:0]   out_y_r;
  logic [LABEL_W-1:0]   out_lab_r;
  logic                 out_bnd_r;
  logic                 out_last_r;

  logic          out_move;
  logic [LW-1:0] rd_prev;
  logic [LW-1:0] rd_above;
  logic [LW-1:0] cval;
  logic          bnd;

  // stage handshake
  assign out_move = !out_valid_r || out_tready;
  assign s1_ready = !s1_valid_r || out_move;

  // verdict: read data lines up with the item held in this stage
  assign rd_prev  = s1_ctl_r.par ? rdata1 : rdata0;
  assign rd_above = s1_ctl_r.par ? rdata0 : rdata1;
  assign cval     = s1_ctl_r.drain ? rd_prev : s1_center_r;
  always_comb begin
    if (s1_ctl_r.drain) begin
      bnd = cval != '0;
    end else begin
      bnd = (cval != '0) &&
            (s1_ctl_r.edge_hit || (rd_above != cval) || (s1_lab_r != cval) ||
             (s1_left_r != cval) || (rd_prev != cval));
    end
  end

  // judge stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= s0_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && s0_ctl.valid) begin
      s1_ctl_r    <= s0_ctl;
      s1_x_r      <= s0_x;
      s1_y_r      <= s0_y;
      s1_lab_r    <= s0_lab;
      s1_left_r   <= s0_left;
      s1_center_r <= s0_center;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_move) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_move && s1_valid_r) begin
      out_x_r    <= CELL_XW'(s1_x_r);
      out_y_r    <= CELL_YW'(s1_y_r);
      out_lab_r  <= LABEL_W'(cval);
      out_bnd_r  <= bnd;
      out_last_r <= s1_ctl_r.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_bnd_r, out_lab_r, out_y_r, out_x_r};
  assign out_tlast  = out_last_r;

  `LGBD_ASSERT_NXT(a_s1_load, s1_ready && s0_ctl.valid, s1_valid_r,
                   "judged item not captured")
  `LGBD_ASSERT_NXT(a_s1_hold, s1_valid_r && !out_move, s1_valid_r && $stable(s1_x_r),
                   "held item lost while result register full")
  `LGBD_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata),
                   "waiting result changed before it was taken")

endmodule

// ===== rtl/label_grid_boundary_detect_unit.sv =====
// Top level of the label grid boundary detect unit
// Results: the result for cell (x, y) passes the judge stage register and the result
//   register after cell (x, y+1) is taken; for the bottom row, after each flush item.
// Throughput: 1 item per cycle unless out_tready stalls; one read, one write per RAM.
// Reset: synchronous, active low; clears the raster counters and pipeline valids
//   and sets grid_width and grid_height to 1024. The line buffers are not cleared.
module label_grid_boundary_detect_unit #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int LABEL_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input items
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [lgbd_pkg::IN_TDATA_W-1:0]  in_tdata,   // [15:0] label
  input  logic                             in_tuser,   // [0] mode
  // result items
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [lgbd_pkg::OUT_TDATA_W-1:0] out_tdata,  // [9:0] cell_x, [19:10] cell_y,
                                                       // [35:20] cell_label,
                                                       // [36] is_boundary, [39:37] zero
  output logic                             out_tlast,  // last
  // configuration writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lgbd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lgbd_pkg::CFG_W-1:0]       cfg_data
);
  import lgbd_pkg::*;

  localparam int XW = $clog2(MAX_WIDTH + 1);
  localparam int YW = $clog2(MAX_HEIGHT + 1);
  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int LW = (LABEL_BITS < LABEL_W) ? LABEL_BITS : LABEL_W;

  logic          we0, we1, re;
  logic [AW-1:0] waddr, raddr0, raddr1;
  logic [LW-1:0] wdata, rdata0, rdata1;
  s0_ctl_t       s0_ctl;
  logic [XW-1:0] s0_x;
  logic [YW-1:0] s0_y;
  logic [LW-1:0] s0_lab, s0_left, s0_center;
  logic          s1_ready;

  assign cfg_ready = 1'b1;
  assign in_tready = s1_ready;

  // counters, configuration and addressing
  lgbd_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .XW         (XW),
    .YW         (YW),
    .AW         (AW),
    .LW         (LW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_tvalid),
    .in_ready  (s1_ready),
    .in_mode   (in_tuser),
    .in_label  (in_tdata[LW-1:0]),
    .rdata0    (rdata0),
    .rdata1    (rdata1),
    .we0       (we0),
    .we1       (we1),
    .waddr     (waddr),
    .wdata     (wdata),
    .re        (re),
    .raddr0    (raddr0),
    .raddr1    (raddr1),
    .s0_ctl    (s0_ctl),
    .s0_x      (s0_x),
    .s0_y      (s0_y),
    .s0_lab    (s0_lab),
    .s0_left   (s0_left),
    .s0_center (s0_center)
  );

  // line buffer for even rows
  lgbd_ram #(
    .WIDTH (LW),
    .DEPTH (MAX_WIDTH),
    .AW    (AW)
  ) u_row_a (
    .clk   (clk),
    .we    (we0),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr0),
    .rdata (rdata0)
  );

  // line buffer for odd rows
  lgbd_ram #(
    .WIDTH (LW),
    .DEPTH (MAX_WIDTH),
    .AW    (AW)
  ) u_row_b (
    .clk   (clk),
    .we    (we1),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr1),
    .rdata (rdata1)
  );

  // verdict and result register
  lgbd_judge #(
    .XW (XW),
    .YW (YW),
    .LW (LW)
  ) u_judge (
    .clk        (clk),
    .rst_n      (rst_n),
    .s0_ctl     (s0_ctl),
    .s0_x       (s0_x),
    .s0_y       (s0_y),
    .s0_lab     (s0_lab),
    .s0_left    (s0_left),
    .s0_center  (s0_center),
    .rdata0     (rdata0),
    .rdata1     (rdata1),
    .s1_ready   (s1_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
